### hdl/nested_if_else_flow_stack_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the nested IF/ELSE flow stack core
// ---------------------------------------------------------------------------
`ifndef NESTED_IF_ELSE_FLOW_STACK_CORE_DEFINES_SVH
`define NESTED_IF_ELSE_FLOW_STACK_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NIFS_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("nifs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NIFS_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("nifs assertion failed");

`endif

### hdl/nifs_pkg.sv
// ---------------------------------------------------------------------------
// nifs_pkg
// Types and codes shared by the nested IF/ELSE flow stack core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nifs_pkg;

    localparam int NEST_MAX = 8;
    localparam int DEPTH_W  = $clog2(NEST_MAX + 1);
    localparam int IDX_W    = (NEST_MAX > 1) ? $clog2(NEST_MAX) : 1;

    // Command codes
    localparam logic [2:0] FUNC_OTHER = 3'd0;
    localparam logic [2:0] FUNC_IF    = 3'd1;
    localparam logic [2:0] FUNC_ELSE  = 3'd2;
    localparam logic [2:0] FUNC_FI    = 3'd3;
    localparam logic [2:0] FUNC_CLEAR = 3'd4;

    // IF condition kinds
    localparam logic [1:0] COND_ERROR   = 2'd0;
    localparam logic [1:0] COND_EXIST   = 2'd1;
    localparam logic [1:0] COND_TRUE    = 2'd2;
    localparam logic [1:0] COND_UNKNOWN = 2'd3;

    // Branch marks
    localparam logic [1:0] MARK_EXEC = 2'd0;
    localparam logic [1:0] MARK_SKIP = 2'd1;
    localparam logic [1:0] MARK_DEAD = 2'd2;

    typedef struct packed {
        logic [2:0] func;
        logic [1:0] cond_kind;
        logic       negate;
        logic       last_failed;
        logic       file_found;
    } nifs_in_t;

    typedef struct packed {
        logic       consumed;
        logic       suppressed;
        logic [3:0] depth_now;
    } nifs_out_t;

endpackage

`default_nettype wire

### hdl/nifs_stack.sv
// ---------------------------------------------------------------------------
// nifs_stack
// Branch mark stack and level count; computes one command's result and
// commits the new stack state when step is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nifs_stack
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire nifs_pkg::nifs_in_t req,
    output nifs_pkg::nifs_out_t     rsp
);
    import nifs_pkg::*;

    logic [1:0]         marks_reg [NEST_MAX];
    logic [1:0]         marks_next [NEST_MAX];
    logic [DEPTH_W-1:0] levels_reg;
    logic [DEPTH_W-1:0] levels_next;
    logic               cur_supp;
    logic               new_supp;
    logic               cond_val;
    logic               consumed;
    logic [IDX_W-1:0]   top_idx;
    logic [IDX_W-1:0]   push_idx;

    assign top_idx  = IDX_W'(levels_reg - 1'b1);
    assign push_idx = IDX_W'(levels_reg);

    always_comb
    begin
        cur_supp = 1'b0;
        for (int i = 0; i < NEST_MAX; i++)
        begin
            if ((DEPTH_W'(i) < levels_reg) && (marks_reg[i] != MARK_EXEC))
            begin
                cur_supp = 1'b1;
            end
        end
    end

    always_comb
    begin
        case (req.cond_kind)
            COND_ERROR:   cond_val = req.last_failed;
            COND_EXIST:   cond_val = req.file_found;
            COND_TRUE:    cond_val = 1'b1;
            COND_UNKNOWN: cond_val = 1'b0;
            default:      cond_val = 1'b0;
        endcase
        cond_val = cond_val ^ req.negate;
    end

    always_comb
    begin
        marks_next  = marks_reg;
        levels_next = levels_reg;
        consumed    = 1'b0;
        case (req.func)
            FUNC_IF:
            begin
                consumed = 1'b1;
                // a full stack drops the push
                if (levels_reg < DEPTH_W'(NEST_MAX))
                begin
                    if (cur_supp)
                    begin
                        marks_next[push_idx] = MARK_DEAD;
                    end
                    else
                    begin
                        marks_next[push_idx] = cond_val ? MARK_EXEC : MARK_SKIP;
                    end
                    levels_next = levels_reg + 1'b1;
                end
            end
            FUNC_ELSE:
            begin
                consumed = 1'b1;
                // flip execute and skip, leave dead alone
                if (levels_reg != '0)
                begin
                    if (marks_reg[top_idx] == MARK_EXEC)
                    begin
                        marks_next[top_idx] = MARK_SKIP;
                    end
                    else if (marks_reg[top_idx] == MARK_SKIP)
                    begin
                        marks_next[top_idx] = MARK_EXEC;
                    end
                end
            end
            FUNC_FI:
            begin
                consumed = 1'b1;
                if (levels_reg != '0)
                begin
                    levels_next = levels_reg - 1'b1;
                end
            end
            FUNC_CLEAR:
            begin
                levels_next = '0;
            end
            default:
            begin
                levels_next = levels_reg;
            end
        endcase
    end

    always_comb
    begin
        new_supp = 1'b0;
        for (int i = 0; i < NEST_MAX; i++)
        begin
            if ((DEPTH_W'(i) < levels_next) && (marks_next[i] != MARK_EXEC))
            begin
                new_supp = 1'b1;
            end
        end
    end

    always_comb
    begin
        rsp.consumed   = consumed;
        rsp.suppressed = new_supp;
        rsp.depth_now  = 4'(levels_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= '0;
        end
        else if (step)
        begin
            levels_reg <= levels_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            marks_reg <= marks_next;
        end
    end

endmodule

`default_nettype wire

### hdl/nested_if_else_flow_stack_core.sv
// ---------------------------------------------------------------------------
// nested_if_else_flow_stack_core
// Nested IF/ELSE/FI branch stack: one command in, one status result out.
//
//   channel | signals                        | moves
//   --------+--------------------------------+-------------------------------
//   in      | in_valid, in_ready, in_data    | one command request
//   out     | out_valid, out_ready, out_data | consumed, suppressed, depth
//
// One request per cycle sustained while the result side is not stalled;
// each passes the input register, then the result register. The stack
// update and the OR over all open marks sit between those two registers.
// Reset clears the level count and both valid flags; marks need no reset.
// A stalled result holds the result register; the input register still
// takes one more request, then in_ready drops until the result is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nested_if_else_flow_stack_core
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire nifs_pkg::nifs_in_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output nifs_pkg::nifs_out_t      out_data
);
    import nifs_pkg::*;

`include "nested_if_else_flow_stack_core_defines.svh"

    nifs_in_t  in_reg;
    logic      in_valid_reg;
    nifs_out_t out_reg;
    logic      out_valid_reg;
    nifs_out_t rsp;
    logic      advance;
    logic      step;

    assign advance   = !out_valid_reg || out_ready;
    assign step      = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    nifs_stack u_stack
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .req   (in_reg),
        .rsp   (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_reg <= in_data;
        end
        if (step)
        begin
            out_reg <= rsp;
        end
    end

    // held request must not move while the result side is stalled
    `NIFS_ASSERT_NEXT(a_hold_req, clk, rst_n, in_valid_reg && !advance,
        in_valid_reg && $stable(in_reg))
    `NIFS_ASSERT_NEXT(a_consumed_code, clk, rst_n, step,
        out_data.consumed == (($past(in_reg.func) == FUNC_IF) ||
        ($past(in_reg.func) == FUNC_ELSE) || ($past(in_reg.func) == FUNC_FI)))
    `NIFS_ASSERT_NOW(a_depth_bound, clk, rst_n, step,
        rsp.depth_now <= 4'(NEST_MAX))
    `NIFS_ASSERT_NEXT(a_clear_empty, clk, rst_n, step && (in_reg.func == FUNC_CLEAR),
        (out_data.depth_now == 4'd0) && !out_data.suppressed)

endmodule

`default_nettype wire

### sim/nested_if_else_flow_stack_core_test.sv
// ---------------------------------------------------------------------------
// nested_if_else_flow_stack_core_test
// Drives IF/ELSE/FI/clear commands into the flow stack core and checks
// every status result against a local copy of the branch stack. It covers
// the empty stack, a full stack, dead marks under a skipped branch, and
// long random command streams. Idling on both sides is varied by phase.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nested_if_else_flow_stack_core_test;

    import nifs_pkg::*;

    localparam logic [2:0] FUNC_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_LAST  = 3'd7;
    localparam int         STALL_LIMIT       = 5000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    nifs_in_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    nifs_out_t out_data;

    // Local copy of the branch stack
    logic [1:0] mark_stack [NEST_MAX];
    int         open_depth = 0;

    nifs_out_t  expected_status_q [$];
    int         error_count      = 0;
    int         sender_idle_pct  = 0;
    int         recv_idle_pct    = 0;
    int         stall_cycles     = 0;

    nested_if_else_flow_stack_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one command to the local stack and return the status it yields.
    function automatic nifs_out_t advance_branch_stack(input nifs_in_t cmd);
        nifs_out_t  status;
        logic       taken;
        logic       under_skip;
        logic [1:0] top_mark;
        under_skip = 1'b0;
        for (int i = 0; i < open_depth; i++)
        begin
            if (mark_stack[i] != MARK_EXEC)
                under_skip = 1'b1;
        end
        status.consumed = 1'b0;
        case (cmd.func)
            FUNC_IF:
            begin
                status.consumed = 1'b1;
                if (open_depth < NEST_MAX)
                begin
                    if (under_skip)
                        mark_stack[open_depth] = MARK_DEAD;
                    else
                    begin
                        case (cmd.cond_kind)
                            COND_ERROR: taken = cmd.last_failed;
                            COND_EXIST: taken = cmd.file_found;
                            COND_TRUE:  taken = 1'b1;
                            default:    taken = 1'b0;
                        endcase
                        taken = taken ^ cmd.negate;
                        mark_stack[open_depth] = taken ? MARK_EXEC : MARK_SKIP;
                    end
                    open_depth++;
                end
            end
            FUNC_ELSE:
            begin
                status.consumed = 1'b1;
                if (open_depth > 0)
                begin
                    top_mark = mark_stack[open_depth - 1];
                    // Flip execute and skip; leave dead alone
                    if (top_mark == MARK_EXEC)
                        mark_stack[open_depth - 1] = MARK_SKIP;
                    else if (top_mark == MARK_SKIP)
                        mark_stack[open_depth - 1] = MARK_EXEC;
                end
            end
            FUNC_FI:
            begin
                status.consumed = 1'b1;
                if (open_depth > 0)
                    open_depth--;
            end
            FUNC_CLEAR:
                open_depth = 0;
            default:
                ;
        endcase
        status.suppressed = 1'b0;
        for (int i = 0; i < open_depth; i++)
        begin
            if (mark_stack[i] != MARK_EXEC)
                status.suppressed = 1'b1;
        end
        status.depth_now = open_depth[3:0];
        return status;
    endfunction

    function automatic nifs_in_t make_cmd(input logic [2:0] func, input logic [1:0] kind,
                                          input logic neg, input logic failed,
                                          input logic found);
        nifs_in_t cmd;
        cmd.func        = func;
        cmd.cond_kind   = kind;
        cmd.negate      = neg;
        cmd.last_failed = failed;
        cmd.file_found  = found;
        return cmd;
    endfunction

    // Hold the request until accepted, then record its expected status.
    task automatic send_cmd(input nifs_in_t cmd);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= cmd;
        do
            @(posedge clk);
        while (!in_ready);
        expected_status_q.push_back(advance_branch_stack(cmd));
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        nifs_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_status_q.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, out_data);
                error_count++;
            end
            else
            begin
                want = expected_status_q.pop_front();
                if (out_data.consumed !== want.consumed)
                begin
                    $display("%0t: consumed expected %0b got %0b",
                             $time, want.consumed, out_data.consumed);
                    error_count++;
                end
                if (out_data.suppressed !== want.suppressed)
                begin
                    $display("%0t: suppressed expected %0b got %0b",
                             $time, want.suppressed, out_data.suppressed);
                    error_count++;
                end
                if (out_data.depth_now !== want.depth_now)
                begin
                    $display("%0t: depth_now expected %0d got %0d",
                             $time, want.depth_now, out_data.depth_now);
                    error_count++;
                end
            end
        end
    end

    // End the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("nested_if_else_flow_stack_core_test failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic test_empty_stack_commands();
        send_cmd(make_cmd(FUNC_ELSE, COND_TRUE, 1'b0, 1'b0, 1'b0));
        send_cmd(make_cmd(FUNC_FI, COND_ERROR, 1'b1, 1'b1, 1'b1));
        send_cmd(make_cmd(FUNC_OTHER, COND_UNKNOWN, 1'b1, 1'b0, 1'b1));
        send_cmd(make_cmd(FUNC_UNUSED_FIRST, COND_TRUE, 1'b0, 1'b1, 1'b0));
        send_cmd(make_cmd(FUNC_UNUSED_FIRST + 3'd1, COND_EXIST, 1'b1, 1'b1, 1'b1));
        send_cmd(make_cmd(FUNC_UNUSED_LAST, COND_ERROR, 1'b0, 1'b0, 1'b0));
        send_cmd(make_cmd(FUNC_CLEAR, COND_UNKNOWN, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_nesting_and_full_stack();
        send_cmd(make_cmd(FUNC_IF, COND_TRUE, 1'b0, 1'b0, 1'b0));
        send_cmd(make_cmd(FUNC_IF, COND_ERROR, 1'b0, 1'b1, 1'b0));
        send_cmd(make_cmd(FUNC_IF, COND_EXIST, 1'b1, 1'b0, 1'b0));
        send_cmd(make_cmd(FUNC_IF, COND_UNKNOWN, 1'b0, 1'b1, 1'b1));
        send_cmd(make_cmd(FUNC_ELSE, COND_ERROR, 1'b0, 1'b0, 1'b0));
        send_cmd(make_cmd(FUNC_IF, COND_ERROR, 1'b0, 1'b0, 1'b1));
        // Skipped branch: the next IF must push dead
        send_cmd(make_cmd(FUNC_IF, COND_TRUE, 1'b0, 1'b0, 1'b0));
        send_cmd(make_cmd(FUNC_ELSE, COND_TRUE, 1'b0, 1'b0, 1'b0));
        send_cmd(make_cmd(FUNC_IF, COND_EXIST, 1'b0, 1'b1, 1'b1));
        send_cmd(make_cmd(FUNC_IF, COND_UNKNOWN, 1'b1, 1'b0, 1'b0));
        // Stack is full here; this IF pushes nothing
        send_cmd(make_cmd(FUNC_IF, COND_TRUE, 1'b1, 1'b1, 1'b1));
        send_cmd(make_cmd(FUNC_FI, COND_TRUE, 1'b0, 1'b0, 1'b0));
        send_cmd(make_cmd(FUNC_ELSE, COND_TRUE, 1'b0, 1'b0, 1'b0));
        send_cmd(make_cmd(FUNC_CLEAR, COND_EXIST, 1'b1, 1'b1, 1'b1));
        send_cmd(make_cmd(FUNC_IF, COND_EXIST, 1'b0, 1'b0, 1'b1));
    endtask

    task automatic test_random_traffic(input int n_cmds, input int s_pct, input int r_pct);
        nifs_in_t cmd;
        int       pick;
        sender_idle_pct = s_pct;
        recv_idle_pct   = r_pct;
        repeat (n_cmds)
        begin
            pick            = $urandom_range(99);
            cmd.cond_kind   = 2'($urandom_range(3));
            cmd.negate      = 1'($urandom_range(1));
            cmd.last_failed = 1'($urandom_range(1));
            cmd.file_found  = 1'($urandom_range(1));
            // Favor IF until full so deep nesting and the full stack come up often
            if (pick < ((open_depth < NEST_MAX) ? 40 : 20))
                cmd.func = FUNC_IF;
            else if (pick < 55)
                cmd.func = FUNC_ELSE;
            else if (pick < 85)
                cmd.func = FUNC_FI;
            else if (pick < 93)
                cmd.func = FUNC_OTHER;
            else if (pick < 96)
                cmd.func = FUNC_CLEAR;
            else
                cmd.func = 3'($urandom_range(FUNC_UNUSED_LAST, FUNC_UNUSED_FIRST));
            send_cmd(cmd);
        end
    endtask

    initial
    begin
        sender_idle_pct = 22;
        recv_idle_pct   = 81;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stack_commands();
        test_nesting_and_full_stack();
        test_random_traffic(700, 22, 81);
        test_random_traffic(700, 81, 22);
        test_random_traffic(600, 0, 0);

        in_valid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("nested_if_else_flow_stack_core_test passed");
        else
            $display("nested_if_else_flow_stack_core_test failed");
        $finish;
    end

endmodule
